// ===== sv/sequencer_voice_note_table_macros.svh =====
// Assertion macros shared by the voice note table RTL.
`ifndef SEQUENCER_VOICE_NOTE_TABLE_MACROS_SVH
`define SEQUENCER_VOICE_NOTE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define SVNT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define SVNT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVNT_ASSERT(name, prop, msg)
`define SVNT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== sv/svnt_pkg.sv =====
// Types and codes of the sequencer voice note table.
`default_nettype none
package svnt_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_NOTE_ON   = 3'd1;
  localparam logic [2:0] OP_NOTE_DUR  = 3'd2;
  localparam logic [2:0] OP_NOTE_OFF  = 3'd3;
  localparam logic [2:0] OP_TRACK_OFF = 3'd4;
  localparam logic [2:0] OP_ALL_OFF   = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;
  localparam logic [2:0] OP_ADD_DUR   = 3'd7;

  // Event kinds.
  localparam logic [1:0] EVT_ON   = 2'd0;
  localparam logic [1:0] EVT_OFF  = 2'd1;
  localparam logic [1:0] EVT_DROP = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [6:0]         track;
    logic [3:0]         channel;
    logic [6:0]         key;
    logic [6:0]         velocity;
    logic [23:0]        length_ticks;
    logic signed [23:0] delta_ticks;
  } req_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [6:0]  event_track;
    logic [3:0]  event_channel;
    logic [6:0]  event_key;
    logic [6:0]  event_velocity;
    logic [31:0] event_time;
    logic        last;
  } evt_t;

  // Identity and velocity of one stored note.
  typedef struct packed {
    logic [6:0] track;
    logic [3:0] channel;
    logic [6:0] key;
    logic [6:0] velocity;
  } note_t;

endpackage
`default_nettype wire

// ===== sv/sequencer_voice_note_table.sv =====
// Top level of the sequencer voice note table: slot memory, scan sequencer and event output.
// The table holds up to VOICES active notes in insertion order, packed at the bottom of a slot
// memory and tracked by a fill count, so the scan never evaluates a slot before it is written.
// A request is taken only while the block is idle. A note on or note with duration is accepted,
// then writes the slot and builds the event, and then hands the event to the output register;
// a full table turns it into a drop event. Tick, note off, track off, all off, clear and add
// duration walk the occupied slots through the single read port of the slot memory, one slot
// per cycle unless stalled, rewriting kept notes down over removed ones; such a request skips
// the walk when the table is empty or the delta of add duration is not positive. One event is
// held back until the next one is found, which lets the final event of a request carry the
// last flag; each emitted event therefore also needs the output register free, and a stalled
// event consumer can hold up the scan. Events report the time counter as it was when the
// request arrived; tick and clear update the counter only after the scan. The configuration
// register event_enable is always ready and is meant to be written while the block is idle;
// with it at zero the table is updated without any event.
`default_nettype none
`include "sequencer_voice_note_table_macros.svh"
module sequencer_voice_note_table #(
  parameter int VOICES      = 16,
  parameter int LENGTH_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_ready,
  input  wire svnt_pkg::req_t req,
  output      logic          evt_valid,
  input  wire logic          evt_ready,
  output      svnt_pkg::evt_t evt,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic          cfg_data
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W = $clog2(VOICES + 1);
  // The positive part of a delta has 23 bits; the sum needs one bit more than either side.
  localparam int SUM_W = ((LENGTH_BITS > 23) ? LENGTH_BITS : 23) + 1;
  localparam logic [SUM_W-1:0] LEN_MAX_W = SUM_W'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(VOICES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_EVAL,
    S_DONE
  } state_t;

  // Slot memory: one write port and one registered read port.
  svnt_pkg::note_t        slot_note   [VOICES];
  logic [31:0]            slot_start  [VOICES];
  logic [LENGTH_BITS-1:0] slot_length [VOICES];

  svnt_pkg::note_t        rd_note;
  logic [31:0]            rd_start;
  logic [LENGTH_BITS-1:0] rd_length;

  state_t          state;
  svnt_pkg::req_t  req_q;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] wr_idx;
  logic            found;
  logic            pend_valid;
  svnt_pkg::evt_t  pend;
  logic [31:0]     tick_count;
  logic            event_enable;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  svnt_pkg::note_t        w_note;
  logic [31:0]            w_start;
  logic [LENGTH_BITS-1:0] w_length;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  logic                   req_take;
  logic                   out_free;
  logic                   id_match;
  logic                   hit;
  logic                   stall;
  logic                   evt_load;
  logic                   last_slot;
  logic [SUM_W-1:0]       len_sum;
  logic [LENGTH_BITS-1:0] len_kept;
  logic [LENGTH_BITS-1:0] len_in;
  svnt_pkg::evt_t         hit_evt;
  svnt_pkg::evt_t         ins_evt;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_take  = req_valid && req_ready;
  // The output register can take a new event this cycle.
  assign out_free  = !evt_valid || evt_ready;

  assign id_match  = (rd_note.track == req_q.track) && (rd_note.channel == req_q.channel) &&
                     (rd_note.key == req_q.key);
  assign last_slot = ((scan_idx + CNT_W'(1)) == used);
  assign len_in    = LENGTH_BITS'(req_q.length_ticks);

  // Add duration on a timed note of the requested track, saturating at the field maximum.
  assign len_sum = SUM_W'(rd_length) + SUM_W'(req_q.delta_ticks[22:0]);
  always_comb begin
    len_kept = rd_length;
    if (req_q.opcode == svnt_pkg::OP_ADD_DUR && rd_note.track == req_q.track &&
        rd_length != '0) begin
      len_kept = (len_sum > LEN_MAX_W) ? LENGTH_BITS'(LEN_MAX_W) : LENGTH_BITS'(len_sum);
    end
  end

  // Removal test for the slot under the scan.
  always_comb begin
    case (req_q.opcode)
      svnt_pkg::OP_TICK:
        hit = (rd_length != '0) && ((tick_count - rd_start) >= 32'(rd_length));
      svnt_pkg::OP_NOTE_OFF:   hit = id_match && !found;
      svnt_pkg::OP_TRACK_OFF:  hit = (rd_note.track == req_q.track);
      svnt_pkg::OP_ALL_OFF,
      svnt_pkg::OP_CLEAR:      hit = 1'b1;
      default:                 hit = 1'b0;
    endcase
  end

  // A removal event has to wait while an older one is held and the output is still full.
  assign stall = hit && event_enable && pend_valid && !out_free;

  // The held event moves into the output register this cycle.
  assign evt_load = ((state == S_EVAL) && hit && event_enable && pend_valid && out_free) ||
                    ((state == S_DONE) && pend_valid && out_free);

  always_comb begin
    hit_evt.event_kind     = svnt_pkg::EVT_OFF;
    hit_evt.event_track    = rd_note.track;
    hit_evt.event_channel  = rd_note.channel;
    hit_evt.event_key      = rd_note.key;
    hit_evt.event_velocity = rd_note.velocity;
    hit_evt.event_time     = tick_count;
    hit_evt.last           = 1'b0;

    ins_evt.event_kind     = (used == FULL) ? svnt_pkg::EVT_DROP : svnt_pkg::EVT_ON;
    ins_evt.event_track    = req_q.track;
    ins_evt.event_channel  = req_q.channel;
    ins_evt.event_key      = req_q.key;
    ins_evt.event_velocity = req_q.velocity;
    ins_evt.event_time     = tick_count;
    ins_evt.last           = 1'b0;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx[IDX_W-1:0];
    w_note    = rd_note;
    w_start   = rd_start;
    w_length  = len_kept;
    rd_en     = 1'b0;
    rd_addr   = IDX_W'(scan_idx + CNT_W'(1));
    unique case (state)
      S_IDLE: begin
        rd_en   = req_take;
        rd_addr = '0;
      end
      S_INSERT: begin
        mem_we    = (used != FULL);
        mem_waddr = used[IDX_W-1:0];
        w_note    = '{track: req_q.track, channel: req_q.channel, key: req_q.key,
                      velocity: req_q.velocity};
        w_start   = tick_count;
        w_length  = (req_q.opcode == svnt_pkg::OP_NOTE_DUR) ? len_in : '0;
      end
      S_EVAL: begin
        mem_we = !stall && !hit;
        rd_en  = !stall && !last_slot;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_note[mem_waddr]   <= w_note;
      slot_start[mem_waddr]  <= w_start;
      slot_length[mem_waddr] <= w_length;
    end
    if (rd_en) begin
      rd_note   <= slot_note[rd_addr];
      rd_start  <= slot_start[rd_addr];
      rd_length <= slot_length[rd_addr];
    end
  end

  // Sequencer, table bookkeeping and the event output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used         <= '0;
      pend_valid   <= 1'b0;
      evt_valid    <= 1'b0;
      tick_count   <= '0;
      event_enable <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        event_enable <= cfg_data;
      end
      if (evt_load) begin
        evt_valid <= 1'b1;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            req_q    <= req;
            scan_idx <= '0;
            wr_idx   <= '0;
            found    <= 1'b0;
            if (req.opcode == svnt_pkg::OP_NOTE_ON || req.opcode == svnt_pkg::OP_NOTE_DUR) begin
              state <= S_INSERT;
            end else if (used == '0 || (req.opcode == svnt_pkg::OP_ADD_DUR &&
                         (req.delta_ticks == 24'sd0 || req.delta_ticks[23]))) begin
              state <= S_DONE;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_INSERT: begin
          if (used != FULL) begin
            used <= used + CNT_W'(1);
          end
          pend       <= ins_evt;
          pend_valid <= event_enable;
          state      <= S_DONE;
        end
        S_EVAL: begin
          if (!stall) begin
            if (hit) begin
              found <= 1'b1;
              if (event_enable) begin
                if (pend_valid) begin
                  evt <= pend;
                end
                pend       <= hit_evt;
                pend_valid <= 1'b1;
              end
            end else begin
              wr_idx <= wr_idx + CNT_W'(1);
            end
            if (last_slot) begin
              used  <= hit ? wr_idx : wr_idx + CNT_W'(1);
              state <= S_DONE;
            end else begin
              scan_idx <= scan_idx + CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          // The held event is the final one of the request.
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              evt <= '{event_kind: pend.event_kind, event_track: pend.event_track,
                       event_channel: pend.event_channel, event_key: pend.event_key,
                       event_velocity: pend.event_velocity,
                       event_time: pend.event_time, last: 1'b1};
            end
            pend_valid <= 1'b0;
            if (req_q.opcode == svnt_pkg::OP_TICK) begin
              tick_count <= tick_count + 32'd1;
            end else if (req_q.opcode == svnt_pkg::OP_CLEAR) begin
              tick_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // While idle no event may be held back from the previous request.
  `SVNT_ASSERT(a_idle_no_pending, req_ready |-> !pend_valid, "event held while idle")
  // The fill count never passes the table size.
  `SVNT_ASSERT_ALWAYS(a_used_bound, !rst |=> used <= FULL, "fill count beyond table size")
  // During a scan the read slot is occupied and the write slot never runs ahead of it.
  `SVNT_ASSERT(a_scan_order, (state == S_EVAL) |-> (scan_idx < used && wr_idx <= scan_idx),
               "scan indexes out of order")

endmodule
`default_nettype wire

// ===== verif/note_event_checker.sv =====
// Checker for the voice note table: mirrors the table, predicts every event and compares.
module note_event_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  svnt_pkg::req_t  req,
  input  logic            evt_valid,
  input  logic            evt_ready,
  input  svnt_pkg::evt_t  evt,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_data,
  output int              mismatch_count,
  output int              events_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          VOICES     = 16;
  localparam logic [23:0] LENGTH_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {SWEEP_EXPIRED, SWEEP_TRACK, SWEEP_ALL} sweep_t;

  // Mirror of the note table, packed at the bottom in insertion order.
  svnt_pkg::note_t slot_note[VOICES];
  logic [31:0]     slot_start[VOICES];
  logic [23:0]     slot_length[VOICES];
  int              fill;
  logic [31:0]     song_time;
  logic            events_on;

  // Events of the request being predicted, and all events still owed by the block.
  svnt_pkg::evt_t burst[VOICES];
  int             burst_len;
  svnt_pkg::evt_t expected_events[$];

  function automatic void log_event(input logic [1:0] kind, input svnt_pkg::note_t nt);
    svnt_pkg::evt_t e;
    if (!events_on) return;
    e.event_kind     = kind;
    e.event_track    = nt.track;
    e.event_channel  = nt.channel;
    e.event_key      = nt.key;
    e.event_velocity = nt.velocity;
    e.event_time     = song_time;
    e.last           = 1'b0;
    burst[burst_len] = e;
    burst_len++;
  endfunction

  function automatic void move_slot(input int from, input int to);
    slot_note[to]   = slot_note[from];
    slot_start[to]  = slot_start[from];
    slot_length[to] = slot_length[from];
  endfunction

  // Removes every note that the sweep selects; kept notes close up in order.
  function automatic void sweep(input sweep_t mode, input logic [6:0] trk);
    int          keep;
    logic        hit;
    logic [31:0] age;
    keep = 0;
    for (int i = 0; i < fill; i++) begin
      age = song_time - slot_start[i];
      case (mode)
        SWEEP_EXPIRED: hit = (slot_length[i] != 24'd0) && (age >= {8'd0, slot_length[i]});
        SWEEP_TRACK:   hit = (slot_note[i].track == trk);
        default:       hit = 1'b1;
      endcase
      if (hit) begin
        log_event(svnt_pkg::EVT_OFF, slot_note[i]);
      end else begin
        move_slot(i, keep);
        keep++;
      end
    end
    fill = keep;
  endfunction

  // Removes the oldest note with the same track, channel and key, if there is one.
  function automatic void release_first(input svnt_pkg::req_t r);
    int hit_at;
    hit_at = -1;
    for (int i = 0; i < fill; i++) begin
      if (hit_at < 0 && slot_note[i].track == r.track && slot_note[i].channel == r.channel &&
          slot_note[i].key == r.key) begin
        hit_at = i;
      end
    end
    if (hit_at >= 0) begin
      log_event(svnt_pkg::EVT_OFF, slot_note[hit_at]);
      for (int i = hit_at; i < fill - 1; i++) move_slot(i + 1, i);
      fill--;
    end
  endfunction

  function automatic void start_note(input svnt_pkg::req_t r, input logic [23:0] len);
    svnt_pkg::note_t nt;
    nt.track    = r.track;
    nt.channel  = r.channel;
    nt.key      = r.key;
    nt.velocity = r.velocity;
    if (fill >= VOICES) begin
      log_event(svnt_pkg::EVT_DROP, nt);
      return;
    end
    slot_note[fill]   = nt;
    slot_start[fill]  = song_time;
    slot_length[fill] = len;
    fill++;
    log_event(svnt_pkg::EVT_ON, nt);
  endfunction

  function automatic void apply_request(input svnt_pkg::req_t r);
    logic [24:0] sum;
    burst_len = 0;
    case (r.opcode)
      svnt_pkg::OP_TICK: begin
        sweep(SWEEP_EXPIRED, 7'd0);
        song_time = song_time + 32'd1;
      end
      svnt_pkg::OP_NOTE_ON:   start_note(r, 24'd0);
      svnt_pkg::OP_NOTE_DUR:  start_note(r, r.length_ticks);
      svnt_pkg::OP_NOTE_OFF:  release_first(r);
      svnt_pkg::OP_TRACK_OFF: sweep(SWEEP_TRACK, r.track);
      svnt_pkg::OP_ALL_OFF:   sweep(SWEEP_ALL, 7'd0);
      svnt_pkg::OP_CLEAR: begin
        sweep(SWEEP_ALL, 7'd0);
        song_time = 32'd0;
      end
      svnt_pkg::OP_ADD_DUR: begin
        // Only a positive delta counts, and only timed notes of the track grow.
        if (!r.delta_ticks[23] && r.delta_ticks != 24'sd0) begin
          for (int i = 0; i < fill; i++) begin
            if (slot_note[i].track == r.track && slot_length[i] != 24'd0) begin
              sum = {1'b0, slot_length[i]} + {1'b0, r.delta_ticks};
              slot_length[i] = sum[24] ? LENGTH_MAX : sum[23:0];
            end
          end
        end
      end
      default: ;
    endcase
    if (burst_len > 0) burst[burst_len - 1].last = 1'b1;
    for (int i = 0; i < burst_len; i++) expected_events = {expected_events, burst[i]};
  endfunction

  function automatic string describe(input svnt_pkg::evt_t e);
    return $sformatf("kind %0d track %0d channel %0d key %0d velocity %0d time %0d last %0d",
                     e.event_kind, e.event_track, e.event_channel, e.event_key,
                     e.event_velocity, e.event_time, e.last);
  endfunction

  function automatic void check_event(input svnt_pkg::evt_t got);
    svnt_pkg::evt_t want;
    if (expected_events.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected event: %s", describe(got));
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind || got.event_track !== want.event_track ||
        got.event_channel !== want.event_channel || got.event_key !== want.event_key ||
        got.event_velocity !== want.event_velocity || got.event_time !== want.event_time ||
        got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("event mismatch, expected %s", describe(want));
        $display("               actual   %s", describe(got));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      song_time = 32'd0;
      events_on = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) events_on = cfg_data;
      if (req_valid && req_ready) apply_request(req);
      if (evt_valid && evt_ready) check_event(evt);
    end
    events_owed = expected_events.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the voice note table: clock, reset, requests, event consumer and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is far shorter than this even with every event stalled at length.
  localparam int CYCLE_LIMIT   = 500000;
  // Enough for a scan of the full table and its overhead, with margin.
  localparam int SETTLE_CYCLES = 40;
  // Long consumer hold-off, enough to back the block up onto its request port.
  localparam int LONG_HOLD     = 300;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  svnt_pkg::req_t req       = '0;
  logic           evt_ready = 1'b0;
  logic           cfg_valid = 1'b0;
  logic           cfg_data  = 1'b0;
  logic           req_ready;
  logic           evt_valid;
  svnt_pkg::evt_t evt;
  logic           cfg_ready;

  int    mismatch_count;
  int    events_owed;
  int    cycle_count = 0;

  // Sender burst bookkeeping and the one-shot trigger for the long hold-off.
  int    burst_left = 0;
  bit    hold_request = 1'b0;

  // Identities of recently started notes, so that most note offs find a match.
  svnt_pkg::note_t recent_notes[8];
  int              recent_wr = 0;

  always #5 clk = ~clk;

  sequencer_voice_note_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  note_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .evt_valid      (evt_valid),
    .evt_ready      (evt_ready),
    .evt            (evt),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .events_owed    (events_owed)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic svnt_pkg::req_t make_req(input logic [2:0] op, input logic [6:0] trk,
                                              input logic [3:0] ch, input logic [6:0] k,
                                              input logic [6:0] vel, input logic [23:0] len,
                                              input logic [23:0] delta);
    svnt_pkg::req_t r;
    r.opcode       = op;
    r.track        = trk;
    r.channel      = ch;
    r.key          = k;
    r.velocity     = vel;
    r.length_ticks = len;
    r.delta_ticks  = delta;
    return r;
  endfunction

  // Random requests draw identities mostly from a small pool so that note offs, track offs
  // and duration updates hit stored notes, and the table regularly runs full. The rest of
  // the time every field takes its whole range.
  function automatic svnt_pkg::req_t random_request();
    svnt_pkg::req_t r;
    int             pick;
    int             depth;
    pick = $urandom_range(0, 99);
    r.opcode = (pick < 24) ? svnt_pkg::OP_TICK :
               (pick < 44) ? svnt_pkg::OP_NOTE_ON :
               (pick < 62) ? svnt_pkg::OP_NOTE_DUR :
               (pick < 76) ? svnt_pkg::OP_NOTE_OFF :
               (pick < 82) ? svnt_pkg::OP_TRACK_OFF :
               (pick < 85) ? svnt_pkg::OP_ALL_OFF :
               (pick < 88) ? svnt_pkg::OP_CLEAR : svnt_pkg::OP_ADD_DUR;
    r.track    = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 3));
    r.channel  = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
    r.key      = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(0, 3));
    r.velocity = 7'($urandom);
    // Mostly short lengths so that ticks expire notes; some untimed, some that never expire.
    case ($urandom_range(0, 9))
      6:       r.length_ticks = 24'd0;
      7:       r.length_ticks = 24'($urandom_range(7, 40));
      8:       r.length_ticks = 24'($urandom);
      9:       r.length_ticks = 24'hFFFFFF - 24'($urandom_range(0, 3));
      default: r.length_ticks = 24'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      5:       r.delta_ticks = 24'd0;
      6:       r.delta_ticks = -24'sd1 * 24'($urandom_range(1, 100));
      7:       r.delta_ticks = 24'($urandom);
      8:       r.delta_ticks = 24'h7FFFFF;
      9:       r.delta_ticks = 24'h800000;
      default: r.delta_ticks = 24'($urandom_range(1, 5));
    endcase
    if (r.opcode == svnt_pkg::OP_NOTE_ON || r.opcode == svnt_pkg::OP_NOTE_DUR) begin
      recent_notes[recent_wr % 8] = '{r.track, r.channel, r.key, r.velocity};
      recent_wr++;
    end else if (r.opcode == svnt_pkg::OP_NOTE_OFF && recent_wr > 0 &&
                 $urandom_range(0, 3) != 0) begin
      depth     = (recent_wr > 8) ? 8 : recent_wr;
      pick      = $urandom_range(0, depth - 1);
      r.track   = recent_notes[pick].track;
      r.channel = recent_notes[pick].channel;
      r.key     = recent_notes[pick].key;
    end
    return r;
  endfunction

  // Offers one request and returns at the falling edge after it was taken. Requests go out
  // in bursts; a burst ends with a random gap, sometimes none, so idle cycles land on every
  // phase of the block's scan.
  task automatic offer(input svnt_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted event has arrived, then lets a request
  // that produces no event finish its scan as well.
  task automatic settle();
    req_valid  <= 1'b0;
    burst_left = 0;
    while (events_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Event consumer: segments of random length, each with its own stall pattern, always
  // ready in some. One long hold-off is started on request from the stimulus.
  initial begin : consumer
    int seg;
    int mode;
    int hold_left;
    hold_left = 0;
    forever begin
      seg  = $urandom_range(8, 60);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          evt_ready <= 1'b0;
        end else begin
          case (mode)
            0:       evt_ready <= 1'b1;
            1:       evt_ready <= ($urandom_range(0, 3) != 0);
            2:       evt_ready <= ($urandom_range(0, 3) == 0);
            default: evt_ready <= 1'($urandom_range(0, 1));
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    write_enable(1'b1);

    // Extreme identities, then timed notes: one that expires on the second tick and one at
    // the largest length, plus a duration request of length zero, which stays untimed.
    offer(make_req(svnt_pkg::OP_NOTE_ON,  7'd127, 4'd15, 7'd127, 7'd127, 24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_NOTE_ON,  7'd0,   4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_NOTE_DUR, 7'd1,   4'd2,  7'd60,  7'd100, 24'd1, 24'd0));
    offer(make_req(svnt_pkg::OP_NOTE_DUR, 7'd1,   4'd2,  7'd61,  7'd101, 24'hFFFFFF, 24'd0));
    offer(make_req(svnt_pkg::OP_NOTE_DUR, 7'd2,   4'd3,  7'd70,  7'd50,  24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_TICK,     7'd0,   4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_TICK,     7'd0,   4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    // The longest note saturates; the most negative delta is ignored.
    offer(make_req(svnt_pkg::OP_ADD_DUR,  7'd1,   4'd0,  7'd0,   7'd0,   24'd0, 24'h7FFFFF));
    offer(make_req(svnt_pkg::OP_ADD_DUR,  7'd1,   4'd0,  7'd0,   7'd0,   24'd0, 24'h800000));
    offer(make_req(svnt_pkg::OP_NOTE_OFF, 7'd0,   4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    // A second note with the same identity: the note off takes the older one.
    offer(make_req(svnt_pkg::OP_NOTE_ON,  7'd127, 4'd15, 7'd127, 7'd1,   24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_NOTE_OFF, 7'd127, 4'd15, 7'd127, 7'd0,   24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_TRACK_OFF, 7'd1,  4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    // Two notes remain; fill the table, overflow it once, then clear all sixteen.
    for (int i = 0; i < 14; i++) begin
      offer(make_req(svnt_pkg::OP_NOTE_ON, 7'(i + 3), 4'(i), 7'(20 + i), 7'(9 * i),
                     24'd0, 24'd0));
    end
    offer(make_req(svnt_pkg::OP_NOTE_ON,  7'd99,  4'd9,  7'd99,  7'd99,  24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_CLEAR,    7'd0,   4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    offer(make_req(svnt_pkg::OP_ALL_OFF,  7'd0,   4'd0,  7'd0,   7'd0,   24'd0, 24'd0));
    settle();

    // The consumer holds off for a long stretch while requests keep coming.
    hold_request = 1'b1;
    repeat (75) offer(random_request());
    settle();
    repeat (75) offer(random_request());
    settle();

    // Silent mode: the table still changes, and no event may appear.
    write_enable(1'b0);
    repeat (60) offer(random_request());
    settle();

    write_enable(1'b1);
    repeat (130) offer(random_request());
    settle();

    if (mismatch_count == 0 && events_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/svnt_pkg.sv
sv/sequencer_voice_note_table.sv
verif/note_event_checker.sv
verif/tb.sv
